### src/i2c_transaction_sequencer_macros.svh
// ---------------------------------------------------------------------------
// I2C transaction sequencer assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef I2C_TRANSACTION_SEQUENCER_MACROS_SVH
`define I2C_TRANSACTION_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
// ante holds in a cycle -> cons holds in the same cycle
`define I2CTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cts assertion failed");
// ante holds in a cycle -> cons holds in the next cycle
`define I2CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cts assertion failed");
`else
`define I2CTS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define I2CTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### src/i2cts_pkg.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer package
// Shared types, codes and the result-building helper.
// ---------------------------------------------------------------------------
package i2cts_pkg;

    localparam logic READ_BIT = 1'b1;

    typedef enum logic [1:0] {
        MODE_BEGIN = 2'd0,
        MODE_WDATA = 2'd1,
        MODE_RESP  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_START   = 3'd1,
        OP_RESTART = 3'd2,
        OP_STOP    = 3'd3,
        OP_WRITE   = 3'd4,
        OP_RD_ACK  = 3'd5,
        OP_RD_NACK = 3'd6
    } bus_op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NACK  = 2'd1,
        ST_LINK  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WADDR_ACK = 3'd1,
        PH_NEED_DATA = 3'd2,
        PH_DATA_ACK  = 3'd3,
        PH_RADDR_ACK = 3'd4,
        PH_READ_WAIT = 3'd5
    } phase_t;

    typedef struct packed {
        bus_op_t    op;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        status_t    status;
        logic       last;
    } result_t;

    // up to two results written into the output queue per transaction
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic result_t res_make(bus_op_t op, logic [7:0] b, logic rv,
                                         logic [7:0] rd, logic dn, status_t st,
                                         logic lst);
        result_t r;
        r.op         = op;
        r.bus_byte   = b;
        r.read_valid = rv;
        r.read_data  = rd;
        r.done_res   = dn;
        r.status     = st;
        r.last       = lst;
        return r;
    endfunction

endpackage

### src/i2cts_seq.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer core
// Phase register and one-pass result generation per accepted transaction.
// ---------------------------------------------------------------------------
`include "i2c_transaction_sequencer_macros.svh"

module i2cts_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [1:0]      mode,
    input  logic [6:0]      addr7,
    input  logic [7:0]      tx_count,
    input  logic [7:0]      rx_count,
    input  logic [7:0]      data_byte,
    input  logic            sda_at_ack,
    input  logic [7:0]      resp_byte,
    input  logic            link_error,
    output i2cts_pkg::push_t push
);
    import i2cts_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [6:0] addr_reg, addr_next;
    logic [7:0] tx_reg, tx_next;
    logic [7:0] rx_reg, rx_next;
    logic [7:0] rx_dec;
    logic       waiting;
    mode_t      mode_c;

    assign mode_c  = mode_t'(mode);
    assign rx_dec  = (rx_reg != 8'd0) ? rx_reg - 8'd1 : 8'd0;
    assign waiting = (phase_reg == PH_WADDR_ACK) || (phase_reg == PH_DATA_ACK) ||
                     (phase_reg == PH_RADDR_ACK) || (phase_reg == PH_READ_WAIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            addr_reg  <= 7'd0;
            tx_reg    <= 8'd0;
            rx_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        if (accept)
        begin
            unique case (mode_c)
                MODE_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        addr_next  = addr7;
                        tx_next    = tx_count;
                        rx_next    = rx_count;
                        phase_next = (tx_count != 8'd0) ? PH_WADDR_ACK : PH_RADDR_ACK;
                    end
                end
                MODE_WDATA:
                begin
                    if (phase_reg == PH_NEED_DATA)
                    begin
                        tx_next    = (tx_reg != 8'd0) ? tx_reg - 8'd1 : 8'd0;
                        phase_next = PH_DATA_ACK;
                    end
                end
                MODE_RESP:
                begin
                    if (waiting)
                    begin
                        if (link_error)
                            phase_next = PH_IDLE;
                        else if (phase_reg == PH_READ_WAIT)
                        begin
                            rx_next    = rx_dec;
                            phase_next = (rx_dec == 8'd0) ? PH_IDLE : PH_READ_WAIT;
                        end
                        else if (sda_at_ack)
                            phase_next = PH_IDLE;
                        else if (phase_reg == PH_WADDR_ACK)
                            phase_next = PH_NEED_DATA;
                        else if (phase_reg == PH_DATA_ACK)
                        begin
                            if (tx_reg != 8'd0)
                                phase_next = PH_NEED_DATA;
                            else if (rx_reg == 8'd0)
                                phase_next = PH_IDLE;
                            else
                                phase_next = PH_RADDR_ACK;
                        end
                        else
                            phase_next = (rx_reg == 8'd0) ? PH_IDLE : PH_READ_WAIT;
                        // stop clears the counts
                        if (phase_next == PH_IDLE)
                        begin
                            tx_next = 8'd0;
                            rx_next = 8'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // results
    always_comb
    begin
        push.cnt = 2'd0;
        push.r0  = res_make(OP_NONE, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK, 1'b0);
        push.r1  = res_make(OP_NONE, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK, 1'b1);
        if (accept)
        begin
            unique case (mode_c)
                MODE_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push.cnt = 2'd2;
                        push.r0  = res_make(OP_START, 8'd0, 1'b0, 8'd0, 1'b0, ST_OK, 1'b0);
                        push.r1  = res_make(OP_WRITE, {addr7, (tx_count == 8'd0)},
                                            1'b0, 8'd0, 1'b0, ST_OK, 1'b1);
                    end
                end
                MODE_WDATA:
                begin
                    if (phase_reg == PH_NEED_DATA)
                    begin
                        push.cnt = 2'd1;
                        push.r0  = res_make(OP_WRITE, data_byte, 1'b0, 8'd0, 1'b0,
                                            ST_OK, 1'b1);
                    end
                end
                MODE_RESP:
                begin
                    if (waiting)
                    begin
                        if (link_error)
                        begin
                            push.cnt = 2'd1;
                            push.r0  = res_make(OP_STOP, 8'd0, 1'b0, 8'd0, 1'b1,
                                                ST_LINK, 1'b1);
                        end
                        else if (phase_reg == PH_READ_WAIT)
                        begin
                            push.cnt = 2'd2;
                            push.r0  = res_make(OP_NONE, 8'd0, 1'b1, resp_byte, 1'b0,
                                                ST_OK, 1'b0);
                            if (rx_dec == 8'd0)
                                push.r1 = res_make(OP_STOP, 8'd0, 1'b0, 8'd0, 1'b1,
                                                   ST_OK, 1'b1);
                            else
                                push.r1 = res_make((rx_dec == 8'd1) ? OP_RD_NACK : OP_RD_ACK,
                                                   8'd0, 1'b0, 8'd0, 1'b0, ST_OK, 1'b1);
                        end
                        else if (sda_at_ack)
                        begin
                            push.cnt = 2'd1;
                            push.r0  = res_make(OP_STOP, 8'd0, 1'b0, 8'd0, 1'b1,
                                                ST_NACK, 1'b1);
                        end
                        else if (phase_reg == PH_DATA_ACK)
                        begin
                            if (tx_reg != 8'd0)
                                push.cnt = 2'd0;
                            else if (rx_reg == 8'd0)
                            begin
                                push.cnt = 2'd1;
                                push.r0  = res_make(OP_STOP, 8'd0, 1'b0, 8'd0, 1'b1,
                                                    ST_OK, 1'b1);
                            end
                            else
                            begin
                                push.cnt = 2'd2;
                                push.r0  = res_make(OP_RESTART, 8'd0, 1'b0, 8'd0, 1'b0,
                                                    ST_OK, 1'b0);
                                push.r1  = res_make(OP_WRITE, {addr_reg, READ_BIT},
                                                    1'b0, 8'd0, 1'b0, ST_OK, 1'b1);
                            end
                        end
                        else if (phase_reg == PH_RADDR_ACK)
                        begin
                            push.cnt = 2'd1;
                            if (rx_reg == 8'd0)
                                push.r0 = res_make(OP_STOP, 8'd0, 1'b0, 8'd0, 1'b1,
                                                   ST_OK, 1'b1);
                            else
                                push.r0 = res_make((rx_reg == 8'd1) ? OP_RD_NACK : OP_RD_ACK,
                                                   8'd0, 1'b0, 8'd0, 1'b0, ST_OK, 1'b1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // a stop result always sends the sequencer back to idle
    `I2CTS_ASSERT_NEXT(a_stop_idles, clk, rst_n, (push.cnt == 2'd1) && (push.r0.op == OP_STOP), (phase_reg == PH_IDLE))

endmodule

### src/i2cts_outq.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer result queue
// Four-entry queue taking up to two results a cycle, draining one a cycle while out_ready is high.
// ---------------------------------------------------------------------------
`include "i2c_transaction_sequencer_macros.svh"

module i2cts_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  i2cts_pkg::push_t    push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cts_pkg::result_t  head
);
    import i2cts_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign out_valid   = (count_reg != 3'd0);
    assign room        = (count_reg <= 3'd2);
    assign pop         = out_valid && out_ready;
    assign head        = entry_reg[rd_ptr_reg];
    assign wr_ptr_next = wr_ptr_reg + push.cnt;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push.cnt} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            entry_reg[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2)
            entry_reg[wr_ptr_reg + 2'd1] <= push.r1;
    end

    `I2CTS_ASSERT_SAME(a_no_overflow, clk, rst_n, (push.cnt != 2'd0), (count_reg <= 3'd2))
    `I2CTS_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, (count_reg <= 3'd4))
    `I2CTS_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && (push.cnt == 2'd0), (count_reg == $past(count_reg) - 3'd1))

endmodule

### src/i2c_transaction_sequencer.sv
// Accepted transactions write their results into the result queue.
// Throughput: one input transaction per cycle while the four-entry result
// queue has two free slots; results leave at one per cycle while out_ready
// is high.
// Reset (rst_n low, asynchronous): phase idle, counts and address cleared,
// result queue emptied.
// ---------------------------------------------------------------------------
// I2C transaction sequencer
// Byte-level I2C master sequencing: start, address, data writes, restart,
// reads with ack/nack and stop with a completion status.
// ---------------------------------------------------------------------------
module i2c_transaction_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    // input transactions
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [6:0] addr7,
    input  logic [7:0] tx_count,
    input  logic [7:0] rx_count,
    input  logic [7:0] data_byte,
    input  logic       sda_at_ack,
    input  logic [7:0] resp_byte,
    input  logic       link_error,
    // result transactions
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] bus_op,
    output logic [7:0] bus_byte,
    output logic       read_valid,
    output logic [7:0] read_data,
    output logic       done_res,
    output logic [1:0] status,
    output logic       last
);
    import i2cts_pkg::*;

    logic    accept;
    logic    room;
    push_t   push;
    result_t head;

    // Ready depends only on queue occupancy: two free slots cover the worst
    // case of two results from one transaction, so ready never waits on
    // out_ready directly, but pending results that fill the queue stall input.
    assign in_ready = room;
    assign accept   = in_valid && room;

    // Sequencer: decodes the transaction against the current phase and
    // builds zero, one or two results in the same cycle.
    i2cts_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .addr7      (addr7),
        .tx_count   (tx_count),
        .rx_count   (rx_count),
        .data_byte  (data_byte),
        .sda_at_ack (sda_at_ack),
        .resp_byte  (resp_byte),
        .link_error (link_error),
        .push       (push)
    );

    // Result queue: registered entries, head presented straight to the port.
    i2cts_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign bus_op     = head.op;
    assign bus_byte   = head.bus_byte;
    assign read_valid = head.read_valid;
    assign read_data  = head.read_data;
    assign done_res   = head.done_res;
    assign status     = head.status;
    assign last       = head.last;

endmodule

### tb/tb_top.sv
// ---------------------------------------------------------------------------
// I2C transaction sequencer testbench
// Drives begin commands, write bytes and bus responses through the input
// channel and checks every bus operation against a cycle-free prediction of
// the sequencer. Runs directed corner cases first, then protocol-aware random
// traffic under several idling mixes and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cts_pkg::*;

    localparam int           CYCLE_LIMIT  = 1_000_000;
    localparam int           HOLD_CYCLES  = 200;
    localparam int           DRAIN_CYCLES = 16;
    localparam int           PHASE_ITEMS  = 400;
    localparam int           MAX_PRINTS   = 40;
    // mode code outside the defined set; the block must ignore it
    localparam logic [1:0]   MODE_SPARE   = 2'd3;

    // one input transaction as the driver presents it
    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] addr;
        logic [7:0] tx;
        logic [7:0] rx;
        logic [7:0] data;
        logic       sda;
        logic [7:0] resp;
        logic       lerr;
    } in_item_t;

    // sequencer state as tracked by the predictor
    typedef struct packed {
        phase_t     phase;
        logic [6:0] addr;
        logic [7:0] tx_left;
        logic [7:0] rx_left;
    } seq_state_t;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] mode       = '0;
    logic [6:0] addr7      = '0;
    logic [7:0] tx_count   = '0;
    logic [7:0] rx_count   = '0;
    logic [7:0] data_byte  = '0;
    logic       sda_at_ack = 1'b0;
    logic [7:0] resp_byte  = '0;
    logic       link_error = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [2:0] bus_op;
    logic [7:0] bus_byte;
    logic       read_valid;
    logic [7:0] read_data;
    logic       done_res;
    logic [1:0] status;
    logic       last;

    i2c_transaction_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .addr7      (addr7),
        .tx_count   (tx_count),
        .rx_count   (rx_count),
        .data_byte  (data_byte),
        .sda_at_ack (sda_at_ack),
        .resp_byte  (resp_byte),
        .link_error (link_error),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .bus_op     (bus_op),
        .bus_byte   (bus_byte),
        .read_valid (read_valid),
        .read_data  (read_data),
        .done_res   (done_res),
        .status     (status),
        .last       (last)
    );

    // pending input transactions, filled by the stimulus, drained by the driver
    in_item_t   pending_q [$];
    // bus operations the sequencer still owes us, oldest first
    result_t    bus_expect_q [$];

    seq_state_t seq_model;      // predictor state, advanced on accepted inputs
    seq_state_t gen_shadow;     // stimulus-side copy, advanced on queued inputs

    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    int holds_asked     = 0;
    int holds_granted   = 0;
    int hold_left       = 0;
    logic in_taken      = 1'b0;

    int items_queued    = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int cycle_count     = 0;
    int done_ok         = 0;
    int done_nack       = 0;
    int done_link       = 0;

    // -----------------------------------------------------------------------
    // Clock and cycle-limit watchdog
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    function automatic result_t bus_result(bus_op_t op, logic [7:0] b);
        result_t r;
        r          = '0;
        r.op       = op;
        r.bus_byte = b;
        return r;
    endfunction

    // stop with completion status; sequencer drops back to idle
    function automatic result_t close_txn(inout seq_state_t st, input status_t s);
        result_t r;
        st.phase    = PH_IDLE;
        st.tx_left  = '0;
        st.rx_left  = '0;
        r           = bus_result(OP_STOP, 8'h00);
        r.done_res  = 1'b1;
        r.status    = s;
        return r;
    endfunction

    // next read: the final byte is nacked
    function automatic result_t next_read(inout seq_state_t st);
        st.phase = PH_READ_WAIT;
        return bus_result(st.rx_left == 8'd1 ? OP_RD_NACK : OP_RD_ACK, 8'h00);
    endfunction

    // Advances st by one input transaction, returns how many bus results it
    // causes (0..2) in res[0], res[1].
    function automatic int seq_predict(inout seq_state_t st, input in_item_t it,
                                       output result_t [1:0] res);
        int k;
        k   = 0;
        res = '0;
        case (it.mode)
            MODE_BEGIN:
            begin
                if (st.phase == PH_IDLE)
                begin
                    // counts are 8 bits wide, so the length cap never bites
                    st.addr    = it.addr;
                    st.tx_left = it.tx;
                    st.rx_left = it.rx;
                    res[k] = bus_result(OP_START, 8'h00);
                    k++;
                    if (st.tx_left != 8'd0)
                    begin
                        res[k]   = bus_result(OP_WRITE, {st.addr, 1'b0});
                        st.phase = PH_WADDR_ACK;
                    end
                    else
                    begin
                        // read address straight away; doubles as a probe
                        res[k]   = bus_result(OP_WRITE, {st.addr, READ_BIT});
                        st.phase = PH_RADDR_ACK;
                    end
                    k++;
                end
            end
            MODE_WDATA:
            begin
                if (st.phase == PH_NEED_DATA)
                begin
                    res[k] = bus_result(OP_WRITE, it.data);
                    k++;
                    if (st.tx_left != 8'd0)
                        st.tx_left = st.tx_left - 8'd1;
                    st.phase = PH_DATA_ACK;
                end
            end
            MODE_RESP:
            begin
                if (st.phase != PH_IDLE && st.phase != PH_NEED_DATA)
                begin
                    if (it.lerr)
                    begin
                        res[k] = close_txn(st, ST_LINK);
                        k++;
                    end
                    else if (st.phase == PH_READ_WAIT)
                    begin
                        // ack level is meaningless here
                        res[k]            = bus_result(OP_NONE, 8'h00);
                        res[k].read_valid = 1'b1;
                        res[k].read_data  = it.resp;
                        k++;
                        if (st.rx_left != 8'd0)
                            st.rx_left = st.rx_left - 8'd1;
                        if (st.rx_left == 8'd0)
                            res[k] = close_txn(st, ST_OK);
                        else
                            res[k] = next_read(st);
                        k++;
                    end
                    else if (it.sda)
                    begin
                        res[k] = close_txn(st, ST_NACK);
                        k++;
                    end
                    else if (st.phase == PH_WADDR_ACK)
                    begin
                        st.phase = PH_NEED_DATA;
                    end
                    else if (st.phase == PH_DATA_ACK)
                    begin
                        if (st.tx_left != 8'd0)
                            st.phase = PH_NEED_DATA;
                        else if (st.rx_left == 8'd0)
                        begin
                            res[k] = close_txn(st, ST_OK);
                            k++;
                        end
                        else
                        begin
                            res[k] = bus_result(OP_RESTART, 8'h00);
                            k++;
                            res[k]   = bus_result(OP_WRITE, {st.addr, READ_BIT});
                            k++;
                            st.phase = PH_RADDR_ACK;
                        end
                    end
                    else
                    begin
                        // read address acked
                        if (st.rx_left == 8'd0)
                            res[k] = close_txn(st, ST_OK);
                        else
                            res[k] = next_read(st);
                        k++;
                    end
                end
            end
            default: ;
        endcase
        if (k > 0)
            res[k-1].last = 1'b1;
        return k;
    endfunction

    // -----------------------------------------------------------------------
    // Mismatch reporting
    // -----------------------------------------------------------------------
    task automatic log_failure(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            log_failure($sformatf("result %0d field %s: got %0d, want %0d",
                                  results_checked, name, got, want));
    endtask

    // -----------------------------------------------------------------------
    // Driver: input channel, changes on the falling edge
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin : input_drive
        in_item_t nx;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                nx          = pending_q.pop_front();
                in_valid   <= 1'b1;
                mode       <= nx.mode;
                addr7      <= nx.addr;
                tx_count   <= nx.tx;
                rx_count   <= nx.rx;
                data_byte  <= nx.data;
                sda_at_ack <= nx.sda;
                resp_byte  <= nx.resp;
                link_error <= nx.lerr;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long output hold-off, counted here so the sender keeps pushing
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_granted < holds_asked)
        begin
            hold_left     <= HOLD_CYCLES;
            holds_granted <= holds_granted + 1;
        end
    end

    // result channel back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= ready_stall_pct);
    end

    // -----------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : channel_monitor
        result_t        got;
        result_t        want;
        result_t [1:0]  fresh;
        in_item_t       seen;
        int             n;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;

            // results leave before any new prediction: the result queue is registered
            if (out_valid && out_ready)
            begin
                got.op         = bus_op_t'(bus_op);
                got.bus_byte   = bus_byte;
                got.read_valid = read_valid;
                got.read_data  = read_data;
                got.done_res   = done_res;
                got.status     = status_t'(status);
                got.last       = last;
                if (bus_expect_q.size() == 0)
                    log_failure($sformatf("unexpected result, bus_op %0d", bus_op));
                else
                begin
                    want = bus_expect_q.pop_front();
                    check_field("bus_op",     got.op,         want.op);
                    check_field("bus_byte",   got.bus_byte,   want.bus_byte);
                    check_field("read_valid", got.read_valid, want.read_valid);
                    check_field("read_data",  got.read_data,  want.read_data);
                    check_field("done_res",   got.done_res,   want.done_res);
                    check_field("status",     got.status,     want.status);
                    check_field("last",       got.last,       want.last);
                    if (want.done_res)
                    begin
                        case (want.status)
                            ST_OK:   done_ok++;
                            ST_NACK: done_nack++;
                            default: done_link++;
                        endcase
                    end
                end
                results_checked++;
            end

            if (in_valid && in_ready)
            begin
                seen = {mode, addr7, tx_count, rx_count, data_byte,
                        sda_at_ack, resp_byte, link_error};
                n = seq_predict(seq_model, seen, fresh);
                for (int i = 0; i < n; i++)
                    bus_expect_q.push_back(fresh[i]);
                items_accepted <= items_accepted + 1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    function automatic in_item_t cmd(logic [1:0] m, logic [6:0] a, logic [7:0] t,
                                     logic [7:0] r, logic [7:0] d, logic s,
                                     logic [7:0] rb, logic le);
        in_item_t it;
        it = {m, a, t, r, d, s, rb, le};
        return it;
    endfunction

    // mostly short transfers, now and then a long one near the maximum
    function automatic logic [7:0] pick_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 8'($urandom_range(3));
        else if (roll < 99)
            return 8'($urandom_range(12, 4));
        else
            return 8'($urandom_range(255, 200));
    endfunction

    // Next item chosen from what the sequencer is waiting for, with some noise
    function automatic in_item_t make_item(seq_state_t gs);
        in_item_t it;
        int       roll;
        it.mode = 2'($urandom_range(3));
        it.addr = 7'($urandom);
        it.tx   = 8'($urandom);
        it.rx   = 8'($urandom);
        it.data = 8'($urandom);
        it.sda  = 1'($urandom);
        it.resp = 8'($urandom);
        it.lerr = 1'($urandom);
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            // noise; never a begin from idle, that would start a huge transfer
            if (gs.phase == PH_IDLE)
                it.mode = 2'($urandom_range(3, 1));
        end
        else
        begin
            case (gs.phase)
                PH_IDLE:
                begin
                    it.mode = MODE_BEGIN;
                    it.tx   = pick_len();
                    it.rx   = pick_len();
                end
                PH_NEED_DATA:
                    it.mode = MODE_WDATA;
                PH_READ_WAIT:
                begin
                    it.mode = MODE_RESP;
                    it.lerr = ($urandom_range(99) < 2);
                end
                default:
                begin
                    it.mode = MODE_RESP;
                    roll    = $urandom_range(99);
                    it.lerr = (roll < 3);
                    it.sda  = (roll >= 3 && roll < 9);
                end
            endcase
        end
        return it;
    endfunction

    // queue one item, report whether the sequencer will act on it
    function automatic bit queue_item(in_item_t it);
        seq_state_t    was;
        result_t [1:0] dummy;
        int            n;
        was = gen_shadow;
        n   = seq_predict(gen_shadow, it, dummy);
        pending_q.push_back(it);
        items_queued++;
        return (n > 0) || (was != gen_shadow);
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (!(items_accepted == items_queued && bus_expect_q.size() == 0));
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input bit hold);
        int useful;
        @(posedge clk);
        sender_idle_pct = send_pct;
        ready_stall_pct = recv_pct;
        if (hold)
            holds_asked++;
        useful = 0;
        while (useful < PHASE_ITEMS)
        begin
            if (queue_item(make_item(gen_shadow)))
                useful++;
        end
        wait_idle();
    endtask

    initial
    begin : stimulus
        bit dummy_hit;
        seq_model  = '{phase: PH_IDLE, default: '0};
        gen_shadow = '{phase: PH_IDLE, default: '0};
        rst_n      = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corner cases, light idling on both sides
        @(posedge clk);
        sender_idle_pct = 23;
        ready_stall_pct = 23;
        // ignored in idle: spare mode, stray response, stray write byte
        dummy_hit = queue_item(cmd(MODE_SPARE, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b1));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_WDATA, 7'h00, 8'h00, 8'h00, 8'h3C, 1'b0, 8'h00, 1'b0));
        // probe of the top address, then a begin while busy
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h7F, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h11, 8'h05, 8'h05, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        // write one byte then read two through a restart
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h00, 8'h01, 8'h02, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        // response while a write byte is wanted is dropped
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1));
        dummy_hit = queue_item(cmd(MODE_WDATA, 7'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 8'h00, 1'b0));
        // write byte while an ack is awaited is dropped
        dummy_hit = queue_item(cmd(MODE_WDATA, 7'h00, 8'h00, 8'h00, 8'h77, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        // sda level ignored on a read byte
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hFF, 1'b0));
        // nack on a data byte
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h55, 8'h01, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_WDATA, 7'h00, 8'h00, 8'h00, 8'h5A, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0));
        // link error on the read address
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h2A, 8'h00, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1));
        // link error during a read: byte not handed out
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h01, 8'h00, 8'h01, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'hC3, 1'b1));
        // address nack on a probe
        dummy_hit = queue_item(cmd(MODE_BEGIN, 7'h40, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        dummy_hit = queue_item(cmd(MODE_RESP,  7'h00, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0));
        wait_idle();

        // random traffic under the idling mixes, the last with a long hold-off
        run_phase(0,  0,  1'b0);
        run_phase(71, 0,  1'b0);
        run_phase(0,  71, 1'b0);
        run_phase(23, 23, 1'b0);
        run_phase(0,  10, 1'b1);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bus_expect_q.size() != 0)
            log_failure($sformatf("%0d expected results never arrived",
                                  bus_expect_q.size()));

        $display("Checked %0d bus results from %0d input transactions over five idling mixes",
                 results_checked, items_accepted);
        $display("Bus transfers closed: %0d ok, %0d nack, %0d link error; %0d mismatches",
                 done_ok, done_nack, done_link, fail_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/i2cts_pkg.sv
src/i2cts_seq.sv
src/i2cts_outq.sv
src/i2c_transaction_sequencer.sv
tb/tb_top.sv
